/* design/sirt_pkg.sv */
// shared constants and types for the radix text block
`timescale 1ns / 1ps
package sirt_pkg;
    localparam int VALUE_BITS  = 32;
    localparam int MAX_SYMBOLS = 16;
    localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);
    localparam int CNT_W       = 5;
    localparam int DIG_CNT_W   = $clog2(VALUE_BITS + 1);
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [CNT_W-1:0] MIN_RADIX = 5'd2;
    localparam logic [1:0] REG_COUNT = 2'd0;
    localparam logic [1:0] REG_LOW   = 2'd1;
    localparam logic [1:0] REG_HIGH  = 2'd2;

    // one classified item passed from front to back
    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } t_job;
endpackage

/* design/sirt_front.sv */
// front part: accepts values, checks the symbol set, forms the magnitude
`timescale 1ns / 1ps
module sirt_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [sirt_pkg::VALUE_BITS-1:0] i_value,
    input  logic [sirt_pkg::CNT_W-1:0]          i_count,
    input  logic [127:0]                        i_syms,
    output logic                                o_job_valid,
    output sirt_pkg::t_job                      o_job,
    input  logic                                i_job_full
);
    import sirt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_PUSH} t_state;
    t_state r_state;
    logic [SYM_IDX_W-1:0] r_i;
    logic r_ok;
    t_job r_job;
    logic [7:0] w_ci;
    logic w_bad;

    assign w_ci = i_syms[{r_i, 3'b000} +: 8];
    // one symbol per cycle: bad if a zero, plus or minus byte, or equal to any later symbol in use
    always_comb begin
        w_bad = (w_ci == 8'h00) || (w_ci == CHAR_PLUS) || (w_ci == CHAR_MINUS);
        for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if (j > int'(r_i) && j < int'(i_count) && i_syms[j*8 +: 8] == w_ci)
                w_bad = 1'b1;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_PUSH);
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_ok    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job.neg <= i_value[VALUE_BITS-1];
                        r_job.mag <= i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
                        r_i   <= '0;
                        r_ok  <= (i_count >= MIN_RADIX)
                              && (i_count <= CNT_W'(MAX_SYMBOLS));
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!r_ok) begin
                        r_state <= S_IDLE;
                    end else if (w_bad) begin
                        r_state <= S_IDLE;
                    end else if (CNT_W'(r_i) + 1'b1 >= i_count) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_PUSH: begin
                    if (!i_job_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* design/sirt_queue.sv */
// two entry queue between front and back
`timescale 1ns / 1ps
module sirt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sirt_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output sirt_pkg::t_job o_job
);
    import sirt_pkg::*;
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_job;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && o_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && o_valid);
        end
    end
endmodule

/* design/sirt_back.sv */
// back part: divides out the digits and streams the characters
`timescale 1ns / 1ps
module sirt_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_valid,
    input  sirt_pkg::t_job                 i_job,
    output logic                           o_job_pop,
    input  logic [sirt_pkg::CNT_W-1:0]     i_count,
    input  logic [127:0]                   i_syms,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_text_char,
    output logic                           o_last_char
);
    import sirt_pkg::*;
    localparam int QW = VALUE_BITS;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_NEXT, S_SIGN, S_EMIT} t_state;
    t_state r_state;
    logic [QW-1:0] r_q;
    logic [SYM_IDX_W:0] r_rem;
    logic [$clog2(QW)-1:0] r_bit;
    logic [SYM_IDX_W-1:0] r_dig [QW];
    logic [DIG_CNT_W-1:0] r_nd;
    logic r_neg;
    logic r_valid;
    logic [7:0] r_char;
    logic r_last;
    logic [SYM_IDX_W+1:0] w_t;
    logic w_load;

    assign o_job_pop   = (r_state == S_IDLE) && i_job_valid;
    assign o_valid     = r_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;
    // restoring division, one quotient bit a cycle
    assign w_t = {r_rem, r_q[QW-1]};
    // output register takes a new character this cycle
    assign w_load = ((r_state == S_SIGN) || (r_state == S_EMIT)) && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall && !w_load) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_q   <= i_job.mag;
                        r_neg <= i_job.neg;
                        r_rem <= '0;
                        r_bit <= '0;
                        r_nd  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_t >= {1'b0, i_count}) begin
                        r_rem <= (SYM_IDX_W+1)'(w_t - {1'b0, i_count});
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_t[SYM_IDX_W:0];
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == ($clog2(QW))'(QW-1)) r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_dig[r_nd[$clog2(QW)-1:0]] <= r_rem[SYM_IDX_W-1:0];
                    r_nd  <= r_nd + 1'b1;
                    r_rem <= '0;
                    r_bit <= '0;
                    if (r_q != '0) r_state <= S_DIV;
                    else r_state <= r_neg ? S_SIGN : S_EMIT;
                end
                S_SIGN: begin
                    if (w_load) begin
                        r_valid <= 1'b1;
                        r_char  <= CHAR_MINUS;
                        r_last  <= 1'b0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_valid <= 1'b1;
                        r_char  <= i_syms[{r_dig[$clog2(QW)'(r_nd - 1'b1)], 3'b000} +: 8];
                        r_last  <= (r_nd == DIG_CNT_W'(1));
                        r_nd    <= r_nd - 1'b1;
                        if (r_nd == DIG_CNT_W'(1)) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* design/signed_integer_to_radix_text_core.sv */
// top level: signed value to radix text converter
// Usage: write symbol_count (index 0), symbols_low (1), symbols_high (2)
// through the config channel while idle; o_cfg_ready is always high.
// Values enter on i_valid/o_stall; characters leave on o_valid/i_stall,
// most significant digit first, o_last_char on the final one.
// The front checks each symbol in use, then hands the magnitude over a
// two entry queue. The back divides with a restoring divider at one
// quotient bit a cycle, a full pass over the value for each digit, then
// sends the characters out, a minus sign first for a negative value; an
// unusable set drops an item after the check.
// Reset loads radix 10 with symbols '0'..'7' and zero bytes above, so
// symbols_high must be written before any output appears.
// A stalled output holds its character and the back waits; the front
// holds o_stall while it checks an item and while the queue is full.
`timescale 1ns / 1ps
module signed_integer_to_radix_text_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [sirt_pkg::VALUE_BITS-1:0] i_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [7:0]                            o_text_char,
    output logic                                  o_last_char,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [1:0]                            i_cfg_index,
    input  logic [63:0]                           i_cfg_data
);
    import sirt_pkg::*;
    logic [CNT_W-1:0] r_count;
    logic [63:0] r_low, r_high;
    logic [127:0] w_syms;
    logic w_fv, w_full, w_pop, w_qv;
    t_job w_fjob, w_qjob;

    assign o_cfg_ready = 1'b1;
    assign w_syms = {r_high, r_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd10;
            r_low   <= 64'h3736353433323130;
            r_high  <= 64'h0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                REG_LOW:   r_low   <= i_cfg_data;
                REG_HIGH:  r_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sirt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_value,
        .i_count(r_count), .i_syms(w_syms),
        .o_job_valid(w_fv), .o_job(w_fjob), .i_job_full(w_full)
    );
    sirt_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_fv), .i_job(w_fjob), .o_full(w_full),
        .i_pop(w_pop), .o_valid(w_qv), .o_job(w_qjob)
    );
    sirt_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_qv), .i_job(w_qjob), .o_job_pop(w_pop),
        .i_count(r_count), .i_syms(w_syms), .o_valid, .i_stall,
        .o_text_char, .o_last_char
    );
endmodule
